### hw/rtl/four_channel_dma_controller_macros.svh
// Assertion macros shared by the DMA controller RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef FOUR_CHANNEL_DMA_CONTROLLER_MACROS_SVH
`define FOUR_CHANNEL_DMA_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FCDMA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fcdma assertion failed");

// Next-cycle implication, disabled during reset.
`define FCDMA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fcdma assertion failed");

`endif

### hw/rtl/fcdma_pkg.sv
// Types, codes and helper functions of the four-channel DMA controller.
// No dependencies; used by all modules.
package fcdma_pkg;

   localparam int CH_NUM            = 4;
   localparam int SHORT_COUNT_LIMIT = 16384;
   localparam int LONG_COUNT_LIMIT  = 65536;
   localparam int SOUND_UNITS       = 4;
   localparam int UNITS_W           = 17;
   localparam int REG_ADDR_W        = 28;
   localparam int ADDR_W            = 32;
   localparam int COUNT_W           = 16;
   localparam int CTL_W             = 11;
   localparam int QUEUE_DEPTH       = 2;
   localparam int QPTR_W            = 1;
   localparam int QCNT_W            = 2;

   // item kinds
   localparam logic [2:0] REQ_WRITE      = 3'd0;
   localparam logic [2:0] REQ_READ       = 3'd1;
   localparam logic [2:0] REQ_TRIGGER    = 3'd2;
   localparam logic [2:0] REQ_STEP       = 3'd3;
   localparam logic [2:0] REQ_STOP_VIDEO = 3'd4;

   // trigger kinds
   localparam logic [1:0] TRIG_VBLANK = 2'd0;
   localparam logic [1:0] TRIG_HBLANK = 2'd1;
   localparam logic [1:0] TRIG_SOUND  = 2'd2;
   localparam logic [1:0] TRIG_VIDEO  = 2'd3;

   // start events
   localparam logic [2:0] EV_IMMEDIATE = 3'd0;
   localparam logic [2:0] EV_VBLANK    = 3'd1;
   localparam logic [2:0] EV_HBLANK    = 3'd2;
   localparam logic [2:0] EV_SOUND     = 3'd3;
   localparam logic [2:0] EV_VIDEO     = 3'd4;
   localparam logic [2:0] EV_NEVER     = 3'd5;

   // timing field
   localparam logic [1:0] TIM_IMMEDIATE = 2'd0;
   localparam logic [1:0] TIM_VBLANK    = 2'd1;
   localparam logic [1:0] TIM_HBLANK    = 2'd2;
   localparam logic [1:0] TIM_SPECIAL   = 2'd3;

   // address modes
   localparam logic [1:0] AM_INC    = 2'd0;
   localparam logic [1:0] AM_DEC    = 2'd1;
   localparam logic [1:0] AM_FIXED  = 2'd2;
   localparam logic [1:0] AM_RELOAD = 2'd3;

   // register offsets
   localparam logic [3:0] OFS_DST_BASE = 4'd4;
   localparam logic [3:0] OFS_CNT_LO   = 4'd8;
   localparam logic [3:0] OFS_CNT_HI   = 4'd9;
   localparam logic [3:0] OFS_CTL_LO   = 4'd10;
   localparam logic [3:0] OFS_CTL_HI   = 4'd11;

   localparam logic [1:0] LONG_CH = 2'd3;

   typedef struct packed {
      logic [2:0] opcode;
      logic [1:0] channel;
      logic [3:0] reg_index;
      logic [7:0] write_data;
      logic [1:0] trigger_kind;
   } req_item_type;

   typedef struct packed {
      logic [7:0]        read_data;
      logic              xfer_valid;
      logic [1:0]        xfer_channel;
      logic [ADDR_W-1:0] src_addr;
      logic [ADDR_W-1:0] dst_addr;
      logic              xfer_word;
      logic              last_of_run;
      logic              irq_valid;
   } rsp_item_type;

   function automatic logic [2:0] start_event(logic [1:0] ch, logic [1:0] timing);
      logic [2:0] ev;
      unique case (timing)
         TIM_IMMEDIATE: ev = EV_IMMEDIATE;
         TIM_VBLANK:    ev = EV_VBLANK;
         TIM_HBLANK:    ev = EV_HBLANK;
         default: begin
            if (ch == 2'd0) ev = EV_NEVER;
            else if (ch == LONG_CH) ev = EV_VIDEO;
            else ev = EV_SOUND;
         end
      endcase
      return ev;
   endfunction

   function automatic logic [REG_ADDR_W-1:0] write_addr(logic [REG_ADDR_W-1:0] r,
         logic is_long, logic [1:0] bsel, logic [7:0] v);
      logic [REG_ADDR_W-1:0] n;
      unique case (bsel)
         2'd0:    n = {r[27:8], v};
         2'd1:    n = {r[27:16], v, r[7:0]};
         2'd2:    n = {r[27:24], v, r[15:0]};
         default: n = {v[3:0], r[23:0]};
      endcase
      if (!is_long) n[27] = 1'b0;
      return n;
   endfunction

   function automatic logic [ADDR_W-1:0] move_addr(logic [ADDR_W-1:0] a, logic [1:0] mode,
         logic word);
      logic [ADDR_W-1:0] s;
      logic [ADDR_W-1:0] n;
      s = word ? ADDR_W'(4) : ADDR_W'(2);
      case (mode)
         AM_DEC:   n = a - s;
         AM_FIXED: n = a;
         default:  n = a + s;
      endcase
      return n;
   endfunction

endpackage

### hw/rtl/fcdma_if.sv
// Valid/ready channel interfaces for DMA request and response items.
// No dependencies.
interface fcdma_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic [1:0] channel;
   logic [3:0] reg_index;
   logic [7:0] write_data;
   logic [1:0] trigger_kind;

   modport source (output valid, opcode, channel, reg_index, write_data, trigger_kind,
                   input ready);
   modport sink   (input valid, opcode, channel, reg_index, write_data, trigger_kind,
                   output ready);
endinterface

interface fcdma_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic        xfer_valid;
   logic [1:0]  xfer_channel;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic        xfer_word;
   logic        last_of_run;
   logic        irq_valid;

   modport source (output valid, read_data, xfer_valid, xfer_channel, src_addr, dst_addr,
                   xfer_word, last_of_run, irq_valid, input ready);
   modport sink   (input valid, read_data, xfer_valid, xfer_channel, src_addr, dst_addr,
                   xfer_word, last_of_run, irq_valid, output ready);
endinterface

### hw/rtl/four_channel_dma_controller.sv
// Four-channel DMA address engine. Every request item (register write, control read,
// trigger, transfer step, stop video capture) yields exactly one response item. Items
// enter a two-entry queue; while the response register is empty or being taken, the
// channel engine retires one per cycle into it, so the sustained rate is one item per
// clock unless stalled; an item passes from its queue entry into the response register.
// A step item emits one transfer unit from the lowest-numbered pending channel; its
// addresses are those before the step.
// Depends on fcdma_pkg, fcdma_if, fcdma_req_queue and fcdma_engine.
module four_channel_dma_controller (
   input  logic        clock,
   input  logic        reset,
   fcdma_req_if.sink   req_ch,
   fcdma_rsp_if.source rsp_ch
);
   import fcdma_pkg::*;

   req_item_type q_item;
   logic         q_valid;
   logic         q_pop;

   fcdma_req_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_pop   (q_pop)
   );

   fcdma_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .rsp     (rsp_ch)
   );

endmodule

### hw/rtl/fcdma_req_queue.sv
// Front end: two-entry request queue between the bus and the channel engine.
// Depends on fcdma_pkg and fcdma_req_if.
module fcdma_req_queue (
   input  logic                 clock,
   input  logic                 reset,
   fcdma_req_if.sink            req,
   output fcdma_pkg::req_item_type q_item,
   output logic                 q_valid,
   input  logic                 q_pop
);
   import fcdma_pkg::*;

   req_item_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push;
   logic               pop;
   req_item_type       push_item;

   assign req.ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push      = req.valid && req.ready;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = entry_ff[rd_ptr_ff];

   assign push_item = '{opcode: req.opcode, channel: req.channel,
                        reg_index: req.reg_index, write_data: req.write_data,
                        trigger_kind: req.trigger_kind};

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hw/rtl/fcdma_engine.sv
// Back end: per-channel register lanes, run control and the response register.
// Depends on fcdma_pkg, fcdma_rsp_if and the macros header.
`include "four_channel_dma_controller_macros.svh"

module fcdma_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  fcdma_pkg::req_item_type q_item,
   input  logic                    q_valid,
   output logic                    q_pop,
   fcdma_rsp_if.source             rsp
);
   import fcdma_pkg::*;

   logic [REG_ADDR_W-1:0] src_reg_ff [CH_NUM];
   logic [REG_ADDR_W-1:0] src_reg_in [CH_NUM];
   logic [REG_ADDR_W-1:0] dst_reg_ff [CH_NUM];
   logic [REG_ADDR_W-1:0] dst_reg_in [CH_NUM];
   logic [COUNT_W-1:0]    cnt_ff     [CH_NUM];
   logic [COUNT_W-1:0]    cnt_in     [CH_NUM];
   logic [ADDR_W-1:0]     src_sh_ff  [CH_NUM];
   logic [ADDR_W-1:0]     src_sh_in  [CH_NUM];
   logic [ADDR_W-1:0]     dst_sh_ff  [CH_NUM];
   logic [ADDR_W-1:0]     dst_sh_in  [CH_NUM];
   logic [UNITS_W-1:0]    units_ff   [CH_NUM];
   logic [UNITS_W-1:0]    units_in   [CH_NUM];
   logic [CTL_W-1:0]      ctl_ff     [CH_NUM];
   logic [CTL_W-1:0]      ctl_in     [CH_NUM];
   logic [CH_NUM-1:0]     pend_ff, pend_in;
   logic [CH_NUM-1:0]     snd_ff, snd_in;
   logic [CH_NUM-1:0]     enable_vec;
   logic [CH_NUM-1:0]     step_oh;
   rsp_item_type          rsp_ff, rsp_in;
   logic                  rsp_valid_ff;
   logic                  advance;
   logic [2:0]            trig_ev;

   assign advance = q_valid && (!rsp_valid_ff || rsp.ready);
   assign q_pop   = advance;
   // lowest-numbered pending channel wins the step
   assign step_oh = pend_ff & (~pend_ff + CH_NUM'(1));

   always_comb begin
      case (q_item.trigger_kind)
         TRIG_VBLANK: trig_ev = EV_VBLANK;
         TRIG_HBLANK: trig_ev = EV_HBLANK;
         TRIG_SOUND:  trig_ev = EV_SOUND;
         default:     trig_ev = EV_VIDEO;
      endcase
   end

   always_comb begin
      for (int c = 0; c < CH_NUM; c++) enable_vec[c] = ctl_ff[c][10];
   end

   always_comb begin
      logic [CTL_W-1:0]  ctl;
      logic [7:0]        wd;
      logic [3:0]        idx;
      logic              is_ch;
      logic              is_long;
      logic              start_run;
      logic              start_snd;
      logic              word;
      logic [UNITS_W-1:0] units_dec;
      logic [UNITS_W-1:0] run_len;
      logic [COUNT_W-1:0] cnt_new;

      wd      = q_item.write_data;
      idx     = q_item.reg_index;
      rsp_in  = '0;
      pend_in = pend_ff;
      snd_in  = snd_ff;
      for (int c = 0; c < CH_NUM; c++) begin
         ctl       = ctl_ff[c];
         is_ch     = (q_item.channel == 2'(c));
         is_long   = (2'(c) == LONG_CH);
         start_run = 1'b0;
         start_snd = 1'b0;
         run_len   = '0;
         cnt_new   = '0;
         src_reg_in[c] = src_reg_ff[c];
         dst_reg_in[c] = dst_reg_ff[c];
         cnt_in[c]     = cnt_ff[c];
         src_sh_in[c]  = src_sh_ff[c];
         dst_sh_in[c]  = dst_sh_ff[c];
         units_in[c]   = units_ff[c];
         ctl_in[c]     = ctl;
         word          = snd_ff[c] | ctl[5];
         units_dec     = units_ff[c] - UNITS_W'(1);

         unique case (q_item.opcode)
            REQ_WRITE: begin
               if (is_ch) begin
                  if (idx < OFS_DST_BASE) begin
                     src_reg_in[c] = write_addr(src_reg_ff[c], is_long, idx[1:0], wd);
                  end else if (idx < OFS_CNT_LO) begin
                     dst_reg_in[c] = write_addr(dst_reg_ff[c], is_long, idx[1:0], wd);
                  end else if (idx == OFS_CNT_LO || idx == OFS_CNT_HI) begin
                     cnt_new = (idx == OFS_CNT_LO) ? {cnt_ff[c][15:8], wd}
                                                   : {wd, cnt_ff[c][7:0]};
                     cnt_in[c] = cnt_new & (is_long ? COUNT_W'(LONG_COUNT_LIMIT - 1)
                                                    : COUNT_W'(SHORT_COUNT_LIMIT - 1));
                  end else if (idx == OFS_CTL_LO) begin
                     ctl_in[c][1:0] = wd[6:5];
                     ctl_in[c][2]   = wd[7];
                  end else if (idx == OFS_CTL_HI) begin
                     ctl_in[c] = {wd[7], wd[6], wd[5:4], wd[3], wd[2], wd[1], wd[0], ctl[2:0]};
                     if (!wd[7]) begin
                        pend_in[c] = 1'b0;
                     end else if (!ctl[10]) begin
                        // rising enable latches the working addresses
                        src_sh_in[c] = ADDR_W'(src_reg_ff[c]);
                        dst_sh_in[c] = ADDR_W'(dst_reg_ff[c]);
                        start_run = (start_event(2'(c), wd[5:4]) == EV_IMMEDIATE);
                     end
                  end
               end
            end
            REQ_READ: begin
               if (is_ch && idx == OFS_CTL_LO)
                  rsp_in.read_data = {ctl[2], ctl[1:0], 5'd0};
               else if (is_ch && idx == OFS_CTL_HI)
                  rsp_in.read_data = {ctl[10], ctl[9], ctl[8:7], ctl[6], ctl[5], ctl[4], ctl[3]};
            end
            REQ_TRIGGER: begin
               if (ctl[10] && start_event(2'(c), ctl[8:7]) == trig_ev) begin
                  start_run = 1'b1;
                  start_snd = (trig_ev == EV_SOUND);
               end
            end
            REQ_STEP: begin
               if (step_oh[c]) begin
                  rsp_in.xfer_valid   = 1'b1;
                  rsp_in.xfer_channel = 2'(c);
                  rsp_in.src_addr     = src_sh_ff[c];
                  rsp_in.dst_addr     = dst_sh_ff[c];
                  rsp_in.xfer_word    = word;
                  if (ctl[3:2] != AM_RELOAD)
                     src_sh_in[c] = move_addr(src_sh_ff[c], ctl[3:2], word);
                  if (!snd_ff[c])
                     dst_sh_in[c] = move_addr(dst_sh_ff[c], ctl[1:0], word);
                  units_in[c] = units_dec;
                  if (units_dec == '0) begin
                     rsp_in.last_of_run = 1'b1;
                     rsp_in.irq_valid   = ctl[9];
                     pend_in[c] = 1'b0;
                     snd_in[c]  = 1'b0;
                     if (!(ctl[4] && ctl[8:7] != TIM_IMMEDIATE && !ctl[6]))
                        ctl_in[c][10] = 1'b0;
                  end
               end
            end
            REQ_STOP_VIDEO: begin
               if (is_long && ctl[8:7] == TIM_SPECIAL) begin
                  ctl_in[c][10] = 1'b0;
                  pend_in[c]    = 1'b0;
               end
            end
            default: ;
         endcase

         // a retrigger of a running channel is ignored
         if (start_run && !pend_ff[c]) begin
            if (cnt_ff[c] != '0) run_len = UNITS_W'(cnt_ff[c]);
            else run_len = is_long ? UNITS_W'(LONG_COUNT_LIMIT) : UNITS_W'(SHORT_COUNT_LIMIT);
            pend_in[c]  = 1'b1;
            snd_in[c]   = start_snd;
            units_in[c] = start_snd ? UNITS_W'(SOUND_UNITS) : run_len;
            if (ctl_in[c][1:0] == AM_RELOAD) dst_sh_in[c] = ADDR_W'(dst_reg_ff[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CH_NUM; c++) begin
            src_reg_ff[c] <= '0;
            dst_reg_ff[c] <= '0;
            cnt_ff[c]     <= '0;
            src_sh_ff[c]  <= '0;
            dst_sh_ff[c]  <= '0;
            units_ff[c]   <= '0;
            ctl_ff[c]     <= '0;
         end
         pend_ff <= '0;
         snd_ff  <= '0;
      end else if (advance) begin
         src_reg_ff <= src_reg_in;
         dst_reg_ff <= dst_reg_in;
         cnt_ff     <= cnt_in;
         src_sh_ff  <= src_sh_in;
         dst_sh_ff  <= dst_sh_in;
         units_ff   <= units_in;
         ctl_ff     <= ctl_in;
         pend_ff    <= pend_in;
         snd_ff     <= snd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.read_data    = rsp_ff.read_data;
   assign rsp.xfer_valid   = rsp_ff.xfer_valid;
   assign rsp.xfer_channel = rsp_ff.xfer_channel;
   assign rsp.src_addr     = rsp_ff.src_addr;
   assign rsp.dst_addr     = rsp_ff.dst_addr;
   assign rsp.xfer_word    = rsp_ff.xfer_word;
   assign rsp.last_of_run  = rsp_ff.last_of_run;
   assign rsp.irq_valid    = rsp_ff.irq_valid;

   `FCDMA_ASSERT_IMP(a_pend_needs_enable, clock, reset, 1'b1,
      (pend_ff & ~enable_vec) == '0)
   `FCDMA_ASSERT_IMP(a_irq_only_last, clock, reset, rsp_valid_ff && rsp_ff.irq_valid,
      rsp_ff.last_of_run && rsp_ff.xfer_valid)
   `FCDMA_ASSERT_IMP(a_idle_fields_zero, clock, reset, rsp_valid_ff && !rsp_ff.xfer_valid,
      rsp_ff.src_addr == '0 && rsp_ff.dst_addr == '0 && !rsp_ff.last_of_run)
   `FCDMA_ASSERT_NEXT(a_step_none_pending, clock, reset,
      advance && q_item.opcode == REQ_STEP && pend_ff == '0,
      rsp_valid_ff && !rsp_ff.xfer_valid)

endmodule
